FILE: design/mtfkl_pkg.sv
// Package for the move-to-front key list core.
// Holds command codes, result status codes, sequencer states and the result bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mtfkl_pkg;

  localparam int KEY_W       = 64;
  localparam int MAX_RESULTS = 16;

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_PROMOTE = 3'd1;
  localparam logic [2:0] MODE_REMOVE  = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_LIST    = 3'd4;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_CHANGE = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_HEAD_WR,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

  typedef struct packed {
    logic             strobe;
    status_t          status;
    logic [KEY_W-1:0] entry_key;
    logic             entry_valid;
    logic [3:0]       position;
    logic [4:0]       entry_count;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

FILE: design/mtfkl_keymem.sv
// Key storage for the move-to-front key list: one write port, one registered read port.
// Depends on mtfkl_pkg for the key width.
`timescale 1ns / 1ps
`default_nettype none
module mtfkl_keymem
  import mtfkl_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IW-1:0]    wr_addr,
  input  wire logic [KEY_W-1:0] wr_data,
  input  wire logic [IW-1:0]    rd_addr,
  output logic      [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: design/mtfkl_seq.sv
// Command sequencer for the move-to-front key list: search, shift, list and count update.
// One shared key comparator and one pointer unit step through the key memory.
// Depends on mtfkl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtfkl_seq
  import mtfkl_pkg::*;
#(
  parameter int ENTRIES   = 16,
  parameter int KEY_BYTES = 8,
  parameter int IW        = 4,
  parameter int CW        = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [2:0]       in_mode,
  input  wire logic [KEY_W-1:0] in_key,
  output logic                  busy,
  output logic                  mem_wr_en,
  output logic      [IW-1:0]    mem_wr_addr,
  output logic      [KEY_W-1:0] mem_wr_data,
  output logic      [IW-1:0]    mem_rd_addr,
  input  wire logic [KEY_W-1:0] mem_rd_data,
  output res_t                  res
);

  localparam logic [KEY_W-1:0] FIT_MASK = (KEY_BYTES >= 8) ? '0 :
                                          ~((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  state_t           state_r, state_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             down_r, down_nxt;
  logic             key_hit;
  logic             in_fits;
  logic [CW-1:0]    src_ptr;
  logic [CW:0]      ptr_p2;
  logic             list_last;

  function automatic res_t mk_res(input status_t st, input logic [CW-1:0] cnt);
    res_t r;
    r             = '0;
    r.strobe      = 1'b1;
    r.status      = st;
    r.entry_count = 5'(cnt);
    r.last        = 1'b1;
    return r;
  endfunction

  assign key_hit   = (mem_rd_data == key_r);
  assign in_fits   = ((in_key & FIT_MASK) == '0);
  assign src_ptr   = down_r ? (ptr_r - 1'b1) : (ptr_r + 1'b1);
  assign ptr_p2    = {1'b0, ptr_r} + (CW+1)'(2);
  assign list_last = ((ptr_r + 1'b1) == count_r) || (32'(ptr_r) == MAX_RESULTS - 1);
  assign busy      = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    ptr_r  <= ptr_nxt;
    down_r <= down_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    ptr_nxt     = ptr_r;
    count_nxt   = count_r;
    down_nxt    = down_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ptr_r[IW-1:0];
    mem_wr_data = mem_rd_data;
    mem_rd_addr = ptr_r[IW-1:0];
    res         = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          key_nxt  = in_key;
          ptr_nxt  = '0;
          case (in_mode)
            MODE_INSERT, MODE_PROMOTE, MODE_REMOVE: begin
              if (in_fits) begin
                state_nxt = S_SEARCH_RD;
              end else if (in_mode == MODE_INSERT) begin
                res = mk_res(STAT_NO_CHANGE, count_r);
              end else begin
                res = mk_res(STAT_NOT_FOUND, count_r);
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
              res       = mk_res(STAT_DONE, '0);
            end
            MODE_LIST: begin
              if (count_r == '0) begin
                res = mk_res(STAT_DONE, '0);
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
            default: begin
              res = mk_res(STAT_DONE, count_r);
            end
          endcase
        end
      end
      S_SEARCH_RD: begin
        if (ptr_r == count_r) begin
          state_nxt = S_IDLE;
          if (mode_r != MODE_INSERT) begin
            res = mk_res(STAT_NOT_FOUND, count_r);
          end else if (count_r == FULL_CNT) begin
            res = mk_res(STAT_FULL, count_r);
          end else if (count_r == '0) begin
            state_nxt = S_HEAD_WR;
          end else begin
            down_nxt  = 1'b1;
            state_nxt = S_MOVE_RD;
          end
        end else begin
          state_nxt = S_SEARCH_CMP;
        end
      end
      S_SEARCH_CMP: begin
        if (key_hit) begin
          state_nxt = S_IDLE;
          case (mode_r)
            MODE_PROMOTE: begin
              if (ptr_r == '0) begin
                res = mk_res(STAT_NO_CHANGE, count_r);
              end else begin
                down_nxt  = 1'b1;
                state_nxt = S_MOVE_RD;
              end
            end
            MODE_REMOVE: begin
              if ((ptr_r + 1'b1) == count_r) begin
                count_nxt = count_r - 1'b1;
                res       = mk_res(STAT_DONE, count_r - 1'b1);
              end else begin
                down_nxt  = 1'b0;
                state_nxt = S_MOVE_RD;
              end
            end
            default: begin
              res = mk_res(STAT_NO_CHANGE, count_r);
            end
          endcase
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = S_SEARCH_RD;
        end
      end
      S_MOVE_RD: begin
        mem_rd_addr = src_ptr[IW-1:0];
        state_nxt   = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        mem_wr_en = 1'b1;
        ptr_nxt   = src_ptr;
        if (down_r) begin
          state_nxt = (ptr_r == CW'(1)) ? S_HEAD_WR : S_MOVE_RD;
        end else if (ptr_p2 == {1'b0, count_r}) begin
          count_nxt = count_r - 1'b1;
          res       = mk_res(STAT_DONE, count_r - 1'b1);
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_HEAD_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        mem_wr_data = key_r;
        state_nxt   = S_IDLE;
        if (mode_r == MODE_INSERT) begin
          count_nxt = count_r + 1'b1;
          res       = mk_res(STAT_DONE, count_r + 1'b1);
        end else begin
          res = mk_res(STAT_DONE, count_r);
        end
      end
      S_LIST_RD: begin
        state_nxt = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        res.strobe      = 1'b1;
        res.status      = STAT_DONE;
        res.entry_key   = mem_rd_data;
        res.entry_valid = 1'b1;
        res.position    = 4'(ptr_r);
        res.entry_count = 5'(count_r);
        res.last        = list_last;
        ptr_nxt         = ptr_r + 1'b1;
        state_nxt       = list_last ? S_IDLE : S_LIST_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/move_to_front_key_list_core.sv
// Channel  | Ports                                    | Handshake
// command  | in_mode, in_key                          | start high while busy low
// result   | out_status, out_entry_key, out_entry_valid,
//          | out_position, out_entry_count, out_last  | out_strobe, one cycle
//
// Clear, unknown commands, oversize keys and listing an empty store are answered from idle.
// Search reads and compares each entry in turn, with an end-of-list check when the key
// is absent; each shifted entry is read through the single memory read port and written
// back; insert and promote then write the head. List returns entries one at a time.
// Reset clears the fill count; there is no memory clearing pass.
// The receiver cannot stall; results are registered and appear the cycle after they form.
// Depends on mtfkl_pkg, mtfkl_keymem and mtfkl_seq.
`timescale 1ns / 1ps
`default_nettype none
module move_to_front_key_list_core
  import mtfkl_pkg::*;
#(
  parameter int ENTRIES   = 16,
  parameter int KEY_BYTES = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       in_mode,
  input  wire logic [KEY_W-1:0] in_key,
  output logic                  out_strobe,
  output logic      [1:0]       out_status,
  output logic      [KEY_W-1:0] out_entry_key,
  output logic                  out_entry_valid,
  output logic      [3:0]       out_position,
  output logic      [4:0]       out_entry_count,
  output logic                  out_last
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic             mem_wr_en;
  logic [IW-1:0]    mem_wr_addr;
  logic [KEY_W-1:0] mem_wr_data;
  logic [IW-1:0]    mem_rd_addr;
  logic [KEY_W-1:0] mem_rd_data;
  res_t             res;
  res_t             res_r;

  mtfkl_keymem #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_keymem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  mtfkl_seq #(
    .ENTRIES  (ENTRIES),
    .KEY_BYTES(KEY_BYTES),
    .IW       (IW),
    .CW       (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_mode),
    .in_key     (in_key),
    .busy       (busy),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .res        (res)
  );

  // hold each result for exactly one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res;
    end
  end

  assign out_strobe      = res_r.strobe;
  assign out_status      = res_r.status;
  assign out_entry_key   = res_r.entry_key;
  assign out_entry_valid = res_r.entry_valid;
  assign out_position    = res_r.position;
  assign out_entry_count = res_r.entry_count;
  assign out_last        = res_r.last;

`ifndef ASSERT_OFF
  a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted transaction neither started nor answered");

  a_entry_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_entry_valid) |-> (out_status == STAT_DONE))
    else $error("listed entry with non-done status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({27'd0, out_entry_count} <= 32'(ENTRIES)))
    else $error("entry count above capacity");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("final result while transaction still running");
`endif

endmodule
`default_nettype wire

FILE: dv/move_to_front_key_list_core_tb.sv
// Self-checking testbench for move_to_front_key_list_core: directed and random command
// traffic, an in-bench move-to-front list predictor and a per-result field compare.
// Depends on mtfkl_pkg and the core RTL.
`timescale 1ns / 1ps
module move_to_front_key_list_core_tb;
  import mtfkl_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int KEY_BYTES  = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int POOL_SIZE  = 24;

  typedef struct {
    logic [2:0]       mode;
    logic [KEY_W-1:0] key;
    int               gap;
    bit               drain;
  } cmd_t;

  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] entry_key;
    logic             entry_valid;
    logic [3:0]       position;
    logic [4:0]       entry_count;
    logic             last;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [2:0]       in_mode = MODE_INSERT;
  logic [KEY_W-1:0] in_key = '0;
  logic             busy;
  logic             out_strobe;
  logic [1:0]       out_status;
  logic [KEY_W-1:0] out_entry_key;
  logic             out_entry_valid;
  logic [3:0]       out_position;
  logic [4:0]       out_entry_count;
  logic             out_last;

  cmd_t             cmd_q[$];
  reply_t           reply_q[$];
  logic [KEY_W-1:0] list_keys[ENTRIES];
  int               list_fill;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int n_accepted;
  int n_predicted;
  int n_results_seen;
  int n_errors;
  int n_lists;
  int n_full;
  int n_hits;
  int peak_fill;
  int hold_cnt;
  int idle_cycles;

  move_to_front_key_list_core #(
    .ENTRIES  (ENTRIES),
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_entry_key  (out_entry_key),
    .out_entry_valid(out_entry_valid),
    .out_position   (out_position),
    .out_entry_count(out_entry_count),
    .out_last       (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void push_reply(status_t st, logic [KEY_W-1:0] k, logic v,
                                     logic [3:0] pos, logic [4:0] cnt, logic lst);
    reply_t r;
    r.status      = st;
    r.entry_key   = k;
    r.entry_valid = v;
    r.position    = pos;
    r.entry_count = cnt;
    r.last        = lst;
    reply_q.push_back(r);
    n_predicted++;
  endfunction

  function automatic int locate_key(logic [KEY_W-1:0] k);
    if (KEY_BYTES < 8 && (k >> (8 * KEY_BYTES)) != 0) return list_fill;
    for (int i = 0; i < list_fill; i++)
      if (list_keys[i] == k) return i;
    return list_fill;
  endfunction

  function automatic void apply_list_cmd(logic [2:0] mode, logic [KEY_W-1:0] k);
    int      idx;
    status_t st;
    st = STAT_DONE;
    case (mode)
      MODE_LIST: begin
        n_lists++;
        if (list_fill == 0) begin
          push_reply(STAT_DONE, '0, 1'b0, 4'd0, 5'd0, 1'b1);
        end else begin
          for (int i = 0; i < list_fill; i++)
            push_reply(STAT_DONE, list_keys[i], 1'b1, 4'(i), 5'(list_fill),
                       i == list_fill - 1);
        end
        return;
      end
      MODE_INSERT: begin
        idx = locate_key(k);
        if (KEY_BYTES < 8 && (k >> (8 * KEY_BYTES)) != 0) begin
          st = STAT_NO_CHANGE;
        end else if (idx < list_fill) begin
          st = STAT_NO_CHANGE;
          n_hits++;
        end else if (list_fill >= ENTRIES) begin
          st = STAT_FULL;
          n_full++;
        end else begin
          for (int i = list_fill; i > 0; i--) list_keys[i] = list_keys[i-1];
          list_keys[0] = k;
          list_fill++;
        end
      end
      MODE_PROMOTE: begin
        idx = locate_key(k);
        if (idx >= list_fill) begin
          st = STAT_NOT_FOUND;
        end else if (idx == 0) begin
          st = STAT_NO_CHANGE;
          n_hits++;
        end else begin
          for (int i = idx; i > 0; i--) list_keys[i] = list_keys[i-1];
          list_keys[0] = k;
          n_hits++;
        end
      end
      MODE_REMOVE: begin
        idx = locate_key(k);
        if (idx >= list_fill) begin
          st = STAT_NOT_FOUND;
        end else begin
          for (int i = idx; i + 1 < list_fill; i++) list_keys[i] = list_keys[i+1];
          list_fill--;
          n_hits++;
        end
      end
      MODE_CLEAR: begin
        list_fill = 0;
      end
      default: begin
      end
    endcase
    if (list_fill > peak_fill) peak_fill = list_fill;
    push_reply(st, '0, 1'b0, 4'd0, 5'(list_fill), 1'b1);
  endfunction

  // driver: one command in flight, gap counted after acceptance
  always @(posedge clk) begin
    cmd_t c;
    logic nxt_start;
    if (!rst_n) begin
      start    <= 1'b0;
      in_mode  <= MODE_INSERT;
      in_key   <= '0;
      hold_cnt <= 0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        apply_list_cmd(in_mode, in_key);
        n_accepted++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (hold_cnt > 0) begin
          hold_cnt <= hold_cnt - 1;
        end else if (cmd_q.size() > 0 &&
                     (!cmd_q[0].drain || n_predicted == n_results_seen)) begin
          c = cmd_q.pop_front();
          nxt_start = 1'b1;
          in_mode  <= c.mode;
          in_key   <= c.key;
          hold_cnt <= c.gap;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor: compare each strobed result against the oldest prediction
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_strobe) begin
      n_results_seen <= n_results_seen + 1;
      if (reply_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("[%0t] unexpected result: status=%0d key=%h valid=%0d pos=%0d cnt=%0d last=%0d",
                   $realtime, out_status, out_entry_key, out_entry_valid, out_position,
                   out_entry_count, out_last);
      end else begin
        e = reply_q.pop_front();
        if (out_status !== e.status || out_entry_key !== e.entry_key ||
            out_entry_valid !== e.entry_valid || out_position !== e.position ||
            out_entry_count !== e.entry_count || out_last !== e.last) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  exp: status=%0d key=%h valid=%0d pos=%0d cnt=%0d last=%0d",
                     e.status, e.entry_key, e.entry_valid, e.position, e.entry_count,
                     e.last);
            $display("  act: status=%0d key=%h valid=%0d pos=%0d cnt=%0d last=%0d",
                     out_status, out_entry_key, out_entry_valid, out_position,
                     out_entry_count, out_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, reply_q.size());
        $display("** move_to_front_key_list_core: FAILED **");
        $finish;
      end
    end
  end

  function automatic void add_cmd(logic [2:0] mode, logic [KEY_W-1:0] k, int gap,
                                  bit drain);
    cmd_t c;
    c.mode  = mode;
    c.key   = k;
    c.gap   = gap;
    c.drain = drain;
    cmd_q.push_back(c);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // per-phase mix: grow, balanced, shrink, grow back-to-back
  function automatic logic [2:0] pick_mode(int phase);
    int r;
    int ins_w, pro_w, rem_w, lst_w, clr_w;
    r = $urandom_range(99);
    case (phase)
      0:       begin ins_w = 55; pro_w = 15; rem_w = 10; lst_w = 12; clr_w = 2; end
      1:       begin ins_w = 35; pro_w = 20; rem_w = 25; lst_w = 12; clr_w = 3; end
      2:       begin ins_w = 20; pro_w = 20; rem_w = 45; lst_w = 10; clr_w = 2; end
      default: begin ins_w = 50; pro_w = 20; rem_w = 15; lst_w = 10; clr_w = 2; end
    endcase
    if (r < ins_w) return MODE_INSERT;
    r -= ins_w;
    if (r < pro_w) return MODE_PROMOTE;
    r -= pro_w;
    if (r < rem_w) return MODE_REMOVE;
    r -= rem_w;
    if (r < lst_w) return MODE_LIST;
    r -= lst_w;
    if (r < clr_w) return MODE_CLEAR;
    return 3'($urandom_range(7, 5));
  endfunction

  initial begin
    logic [2:0]       m;
    logic [KEY_W-1:0] k;
    int               g;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand_key();

    // empty list corner cases
    add_cmd(MODE_LIST,    rand_key(), 0, 1'b0);
    add_cmd(MODE_PROMOTE, key_pool[2], 0, 1'b0);
    add_cmd(MODE_REMOVE,  key_pool[2], 1, 1'b0);
    add_cmd(MODE_CLEAR,   '1, 0, 1'b0);
    // extreme keys, present key, head promote, absent remove, unknown mode
    add_cmd(MODE_INSERT,  '0, 0, 1'b0);
    add_cmd(MODE_INSERT,  '1, 0, 1'b0);
    add_cmd(MODE_INSERT,  '0, 2, 1'b0);
    add_cmd(MODE_PROMOTE, '0, 0, 1'b0);
    add_cmd(MODE_PROMOTE, '0, 0, 1'b0);
    add_cmd(MODE_REMOVE,  key_pool[3], 0, 1'b0);
    add_cmd(MODE_LIST,    '0, 0, 1'b0);
    add_cmd(3'd7,         '1, 0, 1'b0);
    // fill to capacity, refuse one more
    for (int i = 2; i < ENTRIES; i++) add_cmd(MODE_INSERT, key_pool[i], 0, 1'b0);
    add_cmd(MODE_INSERT,  key_pool[ENTRIES], 0, 1'b0);
    add_cmd(MODE_LIST,    '0, 0, 1'b0);
    add_cmd(MODE_PROMOTE, '1, 0, 1'b0);
    add_cmd(MODE_REMOVE,  key_pool[8], 0, 1'b0);
    add_cmd(MODE_CLEAR,   '0, 0, 1'b1);
    add_cmd(MODE_LIST,    '0, 0, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 95; n++) begin
        m = pick_mode(phase);
        k = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(POOL_SIZE - 1)];
        g = (phase == 3) ? 0 : pick_gap();
        add_cmd(m, k, g, (n == 0) || ($urandom_range(49) == 0));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (cmd_q.size() != 0 || start || reply_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d commands and %0d results: %0d list walks, %0d full refusals,",
             n_accepted, n_results_seen, n_lists, n_full);
    $display("%0d key hits, peak occupancy %0d of %0d", n_hits, peak_fill, ENTRIES);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("** move_to_front_key_list_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_errors, reply_q.size());
      $display("** move_to_front_key_list_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mtfkl_pkg.sv
design/mtfkl_keymem.sv
design/mtfkl_seq.sv
design/move_to_front_key_list_core.sv
dv/move_to_front_key_list_core_tb.sv
